[sv/shp_pkg.sv]
// Shared types and constants for the 16-bit pair string hash.
// No dependencies; imported by every module of the block.
package shp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned HalfW  = 16;
  localparam int unsigned HashW  = 32;
  localparam int unsigned HeldW  = 24;
  localparam int unsigned CntW   = 2;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [CntW-1:0] GroupFull = 2'd3;

  // One classified command from the front end to the back end.
  typedef struct packed {
    logic             mix;       // mix one full group of four bytes
    logic [HalfW-1:0] hi;        // first two bytes, big-endian
    logic [HalfW-1:0] lo;        // last two bytes, big-endian
    logic             fin;       // close the key after the optional mix
    logic [CntW-1:0]  tail_cnt;  // pending bytes at the close (0..3)
    logic [HeldW-1:0] tail;      // pending bytes, newest in the low byte
  } op_t;

endpackage

[sv/shp_front.sv]
// Front end: accepts key bytes, groups them by four and issues commands.
// Depends on shp_pkg for op_t and the field widths.
module shp_front import shp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             byte_valid_i,
  input  logic             last_i,
  input  logic             q_full_i,
  output logic             push_o,
  output op_t              op_o
);

  logic [HeldW-1:0] held_q, held_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             accept;
  logic             group_done;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign group_done = byte_valid_i & (cnt_q == GroupFull);

  always_comb begin
    op_o.mix = group_done;
    op_o.hi  = held_q[HeldW-1:ByteW];
    op_o.lo  = {held_q[ByteW-1:0], data_byte_i};
    op_o.fin = last_i;
    if (group_done) begin
      op_o.tail_cnt = '0;
      op_o.tail     = '0;
    end else if (byte_valid_i) begin
      op_o.tail_cnt = cnt_q + 2'd1;
      op_o.tail     = {held_q[HeldW-ByteW-1:0], data_byte_i};
    end else begin
      op_o.tail_cnt = cnt_q;
      op_o.tail     = held_q;
    end
  end

  // Drop beats that neither carry a byte nor close the key.
  assign push_o = accept & (byte_valid_i | last_i);

  always_comb begin
    held_d = held_q;
    cnt_d  = cnt_q;
    if (accept) begin
      if (last_i || group_done) begin
        held_d = '0;
        cnt_d  = '0;
      end else if (byte_valid_i) begin
        held_d = {held_q[HeldW-ByteW-1:0], data_byte_i};
        cnt_d  = cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      cnt_q  <= '0;
    end else begin
      held_q <= held_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

[sv/shp_fifo.sv]
// Short command queue between the front and back ends, flip-flop storage.
// Depends on shp_pkg for op_t and the queue depth.
module shp_fifo import shp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  input  logic pop_i,
  output op_t  op_o,
  output logic full_o,
  output logic empty_o
);

  op_t              mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign op_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + QCntW'(1);
        2'b01:   cnt_q <= cnt_q - QCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[sv/shp_back.sv]
// Back end: folds groups into the running hash, then finishes closed keys
// through a three-stage tail/avalanche pipeline. Depends on shp_pkg.
module shp_back import shp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  op_t              op_i,
  input  logic             q_empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [HashW-1:0] hash_o
);

  logic [HashW-1:0] run_q, run_d;
  logic [HashW-1:0] mix_a, mix_b, mixed;

  logic             s1_vld_q, s2_vld_q, s3_vld_q, out_vld_q;
  logic [HashW-1:0] s1_h_q, s2_h_q, s3_h_q, out_h_q;
  logic [CntW-1:0]  s1_cnt_q;
  logic [HeldW-1:0] s1_tail_q;

  logic [HashW-1:0] t_a, t_b, t_c, tail_h;
  logic [HashW-1:0] a_a, a_b, a_c;
  logic [HashW-1:0] b_a, b_b;
  logic             adv;

  // The whole back end moves only when the output slot can take a result.
  assign adv   = ~out_vld_q | out_ready_i;
  assign pop_o = adv & ~q_empty_i;

  // Group mix on the running hash.
  always_comb begin
    mix_a = run_q + {{(HashW-HalfW){1'b0}}, op_i.hi};
    mix_b = (mix_a << 16) ^ (({{(HashW-HalfW){1'b0}}, op_i.lo} << 11) ^ mix_a);
    mixed = mix_b + (mix_b >> 11);
    run_d = run_q;
    if (pop_o) begin
      run_d = op_i.fin ? '0 : (op_i.mix ? mixed : run_q);
    end
  end

  // Tail mix for 1, 2 or 3 pending bytes.
  always_comb begin
    t_a    = s1_h_q;
    t_b    = s1_h_q;
    t_c    = s1_h_q;
    tail_h = s1_h_q;
    unique case (s1_cnt_q)
      2'd3: begin
        t_a    = s1_h_q + {{(HashW-HalfW){1'b0}}, s1_tail_q[HeldW-1:ByteW]};
        t_b    = t_a ^ (t_a << 16);
        t_c    = t_b ^ ({{(HashW-ByteW){1'b0}}, s1_tail_q[ByteW-1:0]} << 18);
        tail_h = t_c + (t_c >> 11);
      end
      2'd2: begin
        t_a    = s1_h_q + {{(HashW-HalfW){1'b0}}, s1_tail_q[HalfW-1:0]};
        t_b    = t_a ^ (t_a << 11);
        tail_h = t_b + (t_b >> 17);
      end
      2'd1: begin
        t_a    = s1_h_q + {{(HashW-ByteW){1'b0}}, s1_tail_q[ByteW-1:0]};
        t_b    = t_a ^ (t_a << 10);
        tail_h = t_b + (t_b >> 1);
      end
      default: begin
        tail_h = s1_h_q;
      end
    endcase
  end

  // Avalanche, split over two stages.
  always_comb begin
    a_a = s2_h_q ^ (s2_h_q << 3);
    a_b = a_a + (a_a >> 5);
    a_c = a_b ^ (a_b << 2);
    b_a = s3_h_q + (s3_h_q >> 15);
    b_b = b_a ^ (b_a << 10);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      run_q <= run_d;
      if (adv) begin
        s1_vld_q  <= pop_o & op_i.fin;
        s2_vld_q  <= s1_vld_q;
        s3_vld_q  <= s2_vld_q;
        out_vld_q <= s3_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_h_q    <= op_i.mix ? mixed : run_q;
      s1_cnt_q  <= op_i.tail_cnt;
      s1_tail_q <= op_i.tail;
      s2_h_q    <= tail_h;
      s3_h_q    <= a_c;
      out_h_q   <= b_b;
    end
  end

  assign out_valid_o = out_vld_q;
  assign hash_o      = out_h_q;

endmodule

[sv/string_hash_16bit_pairs.sv]
// String hash over a byte stream, one 32-bit hash per key.
// Input beat: one key byte (tdata), tuser = byte present, tlast = end of key.
// Output beat: the finished hash of the key in tdata.
// The front end takes one beat per cycle and packs bytes into groups of four;
// a four-entry command queue feeds the back end, which mixes one group per
// cycle into the running hash while the output is not stalled and finishes
// closed keys in a three-stage pipeline. Throughput: one input beat every
// cycle while the queue has room. A closed key's hash waits behind queued
// commands, then passes the s1, s2, s3 and output registers. A beat with
// tuser and tlast both low is dropped; a closing beat with tuser high adds
// its byte first. Reset clears the running hash, pending bytes, queue and
// pipeline; the next key starts fresh. While a hash waits with m_axis_tready
// low, the back end holds, the queue fills, and s_axis_tready drops once the
// queue is full. Depends on shp_pkg, shp_front, shp_fifo, shp_back.
module string_hash_16bit_pairs import shp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [ByteW-1:0] s_axis_tdata,   // [7:0] data_byte
  input  logic             s_axis_tuser,   // [0] byte_valid
  input  logic             s_axis_tlast,   // last
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [HashW-1:0] m_axis_tdata    // [31:0] hash_value
);

  op_t  push_op, pop_op;
  logic push, pop, q_full, q_empty;

  shp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .data_byte_i  (s_axis_tdata),
    .byte_valid_i (s_axis_tuser),
    .last_i       (s_axis_tlast),
    .q_full_i     (q_full),
    .push_o       (push),
    .op_o         (push_op)
  );

  shp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .pop_i   (pop),
    .op_o    (pop_op),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  shp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (pop_op),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .hash_o      (m_axis_tdata)
  );

endmodule
